FILE: design/line_pixel_generator_macros.svh
// ----------------------------------------------------------------------------
// line_pixel_generator_macros.svh
// Assertion macros shared by the line pixel generator RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_MACROS_SVH
`define LINE_PIXEL_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define LPG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define LPG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define LPG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LPG_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: design/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Types and constants shared by the line pixel generator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ERR_BITS    = COORD_BITS + 1;
  localparam int COLOR_BITS  = 8;
  localparam int S_DATA_BITS = ((4 * COORD_BITS + 4 * COLOR_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = ((2 * COORD_BITS + 4 * COLOR_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] alpha;
  } color_t;

  typedef struct packed {
    logic   active;
    logic   steep;
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    delta_t delta_major;
    delta_t delta_minor;
    err_t   error_term;
    logic   minor_step_negative;
    color_t color;
  } line_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } obuf_status_t;

endpackage

`default_nettype wire

FILE: design/lpg_setup.sv
// ----------------------------------------------------------------------------
// lpg_setup
// Turns two endpoints and a colour into the initial Bresenham line state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpg_setup (
  input  lpg_pkg::coord_t start_x,
  input  lpg_pkg::coord_t start_y,
  input  lpg_pkg::coord_t end_x,
  input  lpg_pkg::coord_t end_y,
  input  lpg_pkg::color_t color,
  output lpg_pkg::line_t  line_init
);
  import lpg_pkg::*;

  err_t   dx;
  err_t   dy;
  delta_t adx;
  delta_t ady;
  logic   steep;
  coord_t a0;
  coord_t a1;
  coord_t b0;
  coord_t b1;
  logic   swap;
  coord_t minor_end;
  delta_t delta_major;

  always_comb begin
    dx  = err_t'(end_x) - err_t'(start_x);
    dy  = err_t'(end_y) - err_t'(start_y);
    adx = dx[ERR_BITS-1] ? delta_t'(-dx) : delta_t'(dx);
    ady = dy[ERR_BITS-1] ? delta_t'(-dy) : delta_t'(dy);

    // A steep line walks along y, so the axes trade places.
    steep = ady > adx;
    a0    = steep ? start_y : start_x;
    a1    = steep ? end_y   : end_x;
    b0    = steep ? start_x : start_y;
    b1    = steep ? end_x   : end_y;

    // Always walk the major axis upwards.
    swap        = a0 > a1;
    minor_end   = swap ? b0 : b1;
    delta_major = steep ? ady : adx;

    line_init.active              = 1'b1;
    line_init.steep               = steep;
    line_init.major_pos           = swap ? a1 : a0;
    line_init.major_end           = swap ? a0 : a1;
    line_init.minor_pos           = swap ? b1 : b0;
    line_init.delta_major         = delta_major;
    line_init.delta_minor         = steep ? adx : ady;
    line_init.error_term          = err_t'({1'b0, delta_major} >> 1);
    line_init.minor_step_negative = !(line_init.minor_pos < minor_end);
    line_init.color               = color;
  end

endmodule

`default_nettype wire

FILE: design/lpg_step.sv
// ----------------------------------------------------------------------------
// lpg_step
// One Bresenham step: emits the current pixel and the state after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpg_step (
  input  lpg_pkg::line_t  line,
  output lpg_pkg::pixel_t pixel,
  output lpg_pkg::line_t  line_adv
);
  import lpg_pkg::*;

  logic last;
  err_t err_sub;

  always_comb begin
    last    = line.major_pos >= line.major_end;
    err_sub = line.error_term - err_t'({1'b0, line.delta_minor});

    pixel.x     = line.steep ? line.minor_pos : line.major_pos;
    pixel.y     = line.steep ? line.major_pos : line.minor_pos;
    pixel.color = line.color;
    pixel.last  = last;

    line_adv = line;
    if (last) begin
      line_adv.active = 1'b0;
    end else begin
      line_adv.major_pos  = line.major_pos + COORD_BITS'(1);
      line_adv.error_term = err_sub;
      // Error went negative: take a minor step and pay back the major delta.
      if (err_sub[ERR_BITS-1]) begin
        line_adv.minor_pos  = line.minor_step_negative ? line.minor_pos - COORD_BITS'(1)
                                                       : line.minor_pos + COORD_BITS'(1);
        line_adv.error_term = err_sub + err_t'({1'b0, line.delta_major});
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/lpg_out_buf.sv
// ----------------------------------------------------------------------------
// lpg_out_buf
// Two-entry output buffer (result register plus skid register).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpg_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lpg_pkg::pixel_t       push_pixel,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lpg_pkg::pixel_t       out_pixel,
  output lpg_pkg::obuf_status_t status
);
  import lpg_pkg::*;

  pixel_t main_pixel;
  pixel_t skid_pixel;
  logic   main_valid;
  logic   skid_valid;
  logic   pop;

  assign pop       = main_valid && out_ready;
  assign ready     = !skid_valid;
  assign out_valid = main_valid;
  assign out_pixel = main_pixel;
  assign status    = '{main_valid: main_valid, skid_valid: skid_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No push can arrive while the skid register is full.
      if (pop) begin
        main_pixel <= skid_pixel;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_pixel <= push_pixel;
        main_valid <= 1'b1;
      end else begin
        skid_pixel <= push_pixel;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// line_pixel_generator
// Bresenham line rasteriser: one pixel beat per advance while a line is active.
// ----------------------------------------------------------------------------
// A start beat (tuser = 0) loads two signed endpoints and an RGBA colour and
// produces no output; it replaces any line in progress. Every advance beat
// (tuser = 1) while a line is active produces one pixel beat, walking from one
// endpoint to the other along the major axis, with tlast set on the final
// pixel; after that the line is finished and further advances produce
// nothing. The block takes one input beat per clock while s_tready is high.
// Each beat is handled by the combinational setup or step logic against the
// line state register, and a pixel is registered before it appears on the
// output. The output side has a result register and a skid register, so an
// input beat is still taken while one pixel waits on a stalled output; s_tready
// only falls when both hold a pixel, and rises again once the output drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_pixel_generator_macros.svh"

module line_pixel_generator (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata, lowest bit first: start_x, start_y, end_x, end_y,
  // color_red, color_green, color_blue, color_alpha.
  input  logic [lpg_pkg::S_DATA_BITS-1:0] s_tdata,
  // s_tuser: req_type (0 = start a line, 1 = advance one pixel).
  input  logic                            s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // m_tdata, lowest bit first: pixel_x, pixel_y, out_red, out_green,
  // out_blue, out_alpha; these already fill whole bytes.
  output logic [lpg_pkg::M_DATA_BITS-1:0] m_tdata,
  // m_tlast: last_pixel.
  output logic                            m_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready
);
  import lpg_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int KB = COLOR_BITS;

  logic         accept;
  req_t         req;
  coord_t       start_x;
  coord_t       start_y;
  coord_t       end_x;
  coord_t       end_y;
  color_t       color;
  line_t        line;
  line_t        line_next;
  line_t        line_init;
  line_t        line_adv;
  pixel_t       pixel;
  pixel_t       out_pixel;
  logic         push;
  obuf_status_t obuf_status;

  assign accept = s_tvalid && s_tready;
  assign req    = req_t'(s_tuser);

  // Unpack the input beat.
  assign start_x     = s_tdata[CB-1:0];
  assign start_y     = s_tdata[2*CB-1:CB];
  assign end_x       = s_tdata[3*CB-1:2*CB];
  assign end_y       = s_tdata[4*CB-1:3*CB];
  assign color.red   = s_tdata[4*CB+KB-1:4*CB];
  assign color.green = s_tdata[4*CB+2*KB-1:4*CB+KB];
  assign color.blue  = s_tdata[4*CB+3*KB-1:4*CB+2*KB];
  assign color.alpha = s_tdata[4*CB+4*KB-1:4*CB+3*KB];

  lpg_setup u_setup (
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .color     (color),
    .line_init (line_init)
  );

  lpg_step u_step (
    .line     (line),
    .pixel    (pixel),
    .line_adv (line_adv)
  );

  // An advance only yields a pixel while a line is active.
  assign push = accept && (req == REQ_ADVANCE) && line.active;

  always_comb begin
    line_next = line;
    if (accept) begin
      unique case (req)
        REQ_START:   line_next = line_init;
        REQ_ADVANCE: if (line.active) line_next = line_adv;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line <= '0;
    end else begin
      line <= line_next;
    end
  end

  lpg_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pixel (pixel),
    .ready      (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_pixel  (out_pixel),
    .status     (obuf_status)
  );

  assign m_tdata = M_DATA_BITS'({out_pixel.color.alpha, out_pixel.color.blue,
                                 out_pixel.color.green, out_pixel.color.red,
                                 out_pixel.y, out_pixel.x});
  assign m_tlast = out_pixel.last;

  // The skid register only fills behind a full result register.
  `LPG_ASSERT_IMP(a_skid_behind_main, clk, rst, obuf_status.skid_valid, obuf_status.main_valid)
  // An active line never walks past its end point.
  `LPG_ASSERT_IMP(a_major_in_range, clk, rst, line.active, line.major_pos <= line.major_end)
  // The error term stays non-negative between steps.
  `LPG_ASSERT_IMP(a_error_nonneg, clk, rst, line.active, !line.error_term[ERR_BITS-1])
  // The minor delta never exceeds the major delta once axes are chosen.
  `LPG_ASSERT_IMP(a_delta_order, clk, rst, line.active, line.delta_minor <= line.delta_major)
  // Emitting the final pixel ends the line.
  `LPG_ASSERT_NEXT(a_last_ends_line, clk, rst, push && pixel.last, !line.active)

endmodule

`default_nettype wire
